// ----- rtl/bba_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types of the buddy block allocator.
package bba_pkg;

  localparam int TOP_BLOCKS_DEF      = 32;
  localparam int MAX_ORDER_DEF       = 10;
  localparam int MIN_BLOCK_BYTES_DEF = 128;

  localparam int SIZE_W   = 18;
  localparam int BLOCK_W  = 15;
  localparam int HDR_W    = 7;
  localparam int BORD_W   = 4;
  localparam int COUNT_W  = 16;
  localparam int BYTES_W  = 23;
  localparam int NEED_W   = 19;
  localparam int UPD_ORD_W = 5;

  localparam logic [HDR_W-1:0] HDR_RESET = 7'd40;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_IGNORED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_SPLIT = 3'd1,
    CMD_TAKE  = 3'd2,
    CMD_MARK  = 3'd3,
    CMD_MERGE = 3'd4
  } cnt_cmd_e;

  // Counter update: kind and the order it applies to (lower order for split/merge).
  typedef struct packed {
    cnt_cmd_e               kind;
    logic [UPD_ORD_W-1:0]   ord;
  } cnt_upd_t;

endpackage

// ----- rtl/bba_in_if.sv -----
`timescale 1ns / 1ps
// Request channel of the buddy block allocator.
interface bba_in_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [SIZE_W-1:0] size;
  logic [BLOCK_W-1:0] block_index;

  modport source (output valid, op, size, block_index, input ready);
  modport sink   (input valid, op, size, block_index, output ready);
endinterface

// ----- rtl/bba_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the buddy block allocator.
interface bba_out_if;
  import bba_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [BLOCK_W-1:0] block_out;
  logic [BORD_W-1:0]  block_order;
  logic [COUNT_W-1:0] free_blocks;
  logic [BYTES_W-1:0] free_bytes;
  logic [COUNT_W-1:0] total_blocks;
  logic [BYTES_W-1:0] total_bytes;
  logic [BYTES_W-1:0] header_total;

  modport source (output valid, status, block_out, block_order, free_blocks, free_bytes,
                  total_blocks, total_bytes, header_total, input ready);
  modport sink   (input valid, status, block_out, block_order, free_blocks, free_bytes,
                  total_blocks, total_bytes, header_total, output ready);
endinterface

// ----- rtl/bba_cell_mem.sv -----
`timescale 1ns / 1ps
// Cell store: one-port synchronous memory with a clearing pass after reset.
module bba_cell_mem import bba_pkg::*; #(
  parameter int TOP_BLOCKS = TOP_BLOCKS_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF,
  localparam int ORD_W  = $clog2(MAX_ORDER + 1),
  localparam int WORD_W = ORD_W + 2,
  localparam int CELL_W = $clog2(TOP_BLOCKS) + MAX_ORDER
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [CELL_W-1:0] addr_i,
  input  logic [WORD_W-1:0] wdata_i,
  output logic [WORD_W-1:0] rdata_o,
  output logic              busy_o
);
  localparam int CELLS = TOP_BLOCKS << MAX_ORDER;

  logic [WORD_W-1:0] cell_mem_q [CELLS];
  logic [WORD_W-1:0] rdata_q;
  logic [CELL_W-1:0] clr_q, clr_d;
  logic              clearing_q, clearing_d;
  logic              wr;
  logic [CELL_W-1:0] waddr;
  logic [WORD_W-1:0] wdat;

  // Top-block heads come up free at the largest order, the rest empty.
  always_comb begin
    clr_d      = clr_q + CELL_W'(1);
    clearing_d = clearing_q && (clr_q != CELL_W'(CELLS - 1));
    if (clearing_q) begin
      wr    = 1'b1;
      waddr = clr_q;
      if (clr_q[MAX_ORDER-1:0] == '0) begin
        wdat = {1'b1, 1'b1, ORD_W'(MAX_ORDER)};
      end else begin
        wdat = '0;
      end
    end else begin
      wr    = en_i && we_i;
      waddr = addr_i;
      wdat  = wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      clr_q      <= clr_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      cell_mem_q[waddr] <= wdat;
    end
    if (en_i && !we_i && !clearing_q) begin
      rdata_q <= cell_mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clearing_q;
endmodule

// ----- rtl/bba_stats.sv -----
`timescale 1ns / 1ps
// Per-order block counters and the sequential usage statistics unit.
module bba_stats import bba_pkg::*; #(
  parameter int TOP_BLOCKS      = TOP_BLOCKS_DEF,
  parameter int MAX_ORDER       = MAX_ORDER_DEF,
  parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cnt_upd_t           upd_i,
  input  logic [HDR_W-1:0]   hdr_i,
  input  logic               start_i,
  output logic               done_o,
  output logic [MAX_ORDER:0] has_free_o,
  output logic [COUNT_W-1:0] free_blocks_o,
  output logic [BYTES_W-1:0] free_bytes_o,
  output logic [COUNT_W-1:0] total_blocks_o,
  output logic [BYTES_W-1:0] total_bytes_o,
  output logic [BYTES_W-1:0] header_total_o
);
  localparam int ORD_W = $clog2(MAX_ORDER + 1);
  localparam int IW    = $clog2(MAX_ORDER + 2);
  localparam int CNT_W = $clog2(TOP_BLOCKS) + MAX_ORDER + 1;

  logic [CNT_W-1:0] fa_q [MAX_ORDER+1];
  logic [CNT_W-1:0] fa_d [MAX_ORDER+1];
  logic [CNT_W-1:0] ba_q [MAX_ORDER+1];
  logic [CNT_W-1:0] ba_d [MAX_ORDER+1];
  logic [CNT_W-1:0] fc_q, fc_d, bc_q, bc_d;

  logic [IW-1:0]        idx_q;
  logic                 run_q, pv_q, plast_q, done_q;
  logic [BYTES_W-1:0]   prod_f_q, prod_b_q, acc_f_q, acc_b_q, ht_q;
  logic [2*BYTES_W-1:0] pf, pb;
  logic [BYTES_W-1:0]   us;
  logic [CNT_W+HDR_W-1:0] ht_prod;
  logic [UPD_ORD_W:0]   ord_p1;

  function automatic logic [BYTES_W-1:0] usable(input logic [IW-1:0] k,
                                                 input logic [HDR_W-1:0] h);
    logic [63:0] by;
    by = 64'(MIN_BLOCK_BYTES) << k;
    return (by > 64'(h)) ? BYTES_W'(by - 64'(h)) : '0;
  endfunction

  assign ord_p1 = {1'b0, upd_i.ord} + (UPD_ORD_W+1)'(1);

  always_comb begin
    fc_d = fc_q;
    bc_d = bc_q;
    for (int i = 0; i <= MAX_ORDER; i++) begin
      fa_d[i] = fa_q[i];
      ba_d[i] = ba_q[i];
      unique case (upd_i.kind)
        CMD_SPLIT: begin
          if (upd_i.ord == UPD_ORD_W'(i)) begin
            fa_d[i] = fa_q[i] + CNT_W'(2);
            ba_d[i] = ba_q[i] + CNT_W'(2);
          end
          if (ord_p1 == (UPD_ORD_W+1)'(i)) begin
            fa_d[i] = fa_q[i] - CNT_W'(1);
            ba_d[i] = ba_q[i] - CNT_W'(1);
          end
        end
        CMD_TAKE: begin
          if (upd_i.ord == UPD_ORD_W'(i)) fa_d[i] = fa_q[i] - CNT_W'(1);
        end
        CMD_MARK: begin
          if (upd_i.ord == UPD_ORD_W'(i)) fa_d[i] = fa_q[i] + CNT_W'(1);
        end
        CMD_MERGE: begin
          if (upd_i.ord == UPD_ORD_W'(i)) begin
            fa_d[i] = fa_q[i] - CNT_W'(2);
            ba_d[i] = ba_q[i] - CNT_W'(2);
          end
          if (ord_p1 == (UPD_ORD_W+1)'(i)) begin
            fa_d[i] = fa_q[i] + CNT_W'(1);
            ba_d[i] = ba_q[i] + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
    unique case (upd_i.kind)
      CMD_SPLIT: begin
        fc_d = fc_q + CNT_W'(1);
        bc_d = bc_q + CNT_W'(1);
      end
      CMD_TAKE:  fc_d = fc_q - CNT_W'(1);
      CMD_MARK:  fc_d = fc_q + CNT_W'(1);
      CMD_MERGE: begin
        fc_d = fc_q - CNT_W'(1);
        bc_d = bc_q - CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        fa_q[i] <= (i == MAX_ORDER) ? CNT_W'(TOP_BLOCKS) : '0;
        ba_q[i] <= (i == MAX_ORDER) ? CNT_W'(TOP_BLOCKS) : '0;
      end
      fc_q <= CNT_W'(TOP_BLOCKS);
      bc_q <= CNT_W'(TOP_BLOCKS);
    end else begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        fa_q[i] <= fa_d[i];
        ba_q[i] <= ba_d[i];
      end
      fc_q <= fc_d;
      bc_q <= bc_d;
    end
  end

  for (genvar g = 0; g <= MAX_ORDER; g++) begin : g_has
    assign has_free_o[g] = (fa_q[g] != '0);
  end

  // One order per cycle: multiply count by usable bytes, then accumulate.
  assign us      = usable(idx_q, hdr_i);
  assign pf      = BYTES_W'(fa_q[idx_q[ORD_W-1:0]]) * us;
  assign pb      = BYTES_W'(ba_q[idx_q[ORD_W-1:0]]) * us;
  assign ht_prod = (CNT_W+HDR_W)'(hdr_i) * (CNT_W+HDR_W)'(bc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      pv_q    <= 1'b0;
      plast_q <= 1'b0;
      done_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      done_q <= pv_q && plast_q;
      pv_q   <= run_q;
      if (start_i) begin
        run_q <= 1'b1;
        idx_q <= '0;
      end else if (run_q) begin
        plast_q <= (idx_q == IW'(MAX_ORDER));
        if (idx_q == IW'(MAX_ORDER)) run_q <= 1'b0;
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_f_q <= '0;
      acc_b_q <= '0;
      ht_q    <= BYTES_W'(ht_prod);
    end else if (pv_q) begin
      acc_f_q <= acc_f_q + prod_f_q;
      acc_b_q <= acc_b_q + prod_b_q;
    end
    if (run_q) begin
      prod_f_q <= BYTES_W'(pf);
      prod_b_q <= BYTES_W'(pb);
    end
  end

  assign done_o         = done_q;
  assign free_blocks_o  = COUNT_W'(fc_q);
  assign total_blocks_o = COUNT_W'(bc_q);
  assign free_bytes_o   = acc_f_q;
  assign total_bytes_o  = acc_b_q;
  assign header_total_o = ht_q;
endmodule

// ----- rtl/buddy_block_allocator_top.sv -----
`timescale 1ns / 1ps
// Allocate: find an order with a free block, scan its block starts, split down to the needed order
//   and run the statistics pass; free: check the block, merge with free buddies, run the statistics pass.
// Throughput: one beat at a time; the single-port cell memory and the scan over it set the rate.
// Reset: asynchronous, active low; a clearing pass over all TOP_BLOCKS << MAX_ORDER cells
//   (32768 by default) rebuilds the cell store while in_i.ready stays low.
// Config writes are taken at any time, including during the clearing pass.
module buddy_block_allocator_top import bba_pkg::*; #(
  parameter int TOP_BLOCKS      = TOP_BLOCKS_DEF,
  parameter int MAX_ORDER       = MAX_ORDER_DEF,
  parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bba_in_if.sink           in_i,
  bba_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [HDR_W-1:0] cfg_data_i
);
  localparam int ORD_W  = $clog2(MAX_ORDER + 1);
  localparam int IW     = $clog2(MAX_ORDER + 2);
  localparam int WORD_W = ORD_W + 2;
  localparam int CELL_W = $clog2(TOP_BLOCKS) + MAX_ORDER;
  localparam logic [63:0] TOP_BYTES = 64'(MIN_BLOCK_BYTES) << MAX_ORDER;
  localparam logic [31:0] CELLS     = 32'(TOP_BLOCKS) << MAX_ORDER;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_PREP  = 12'b000000000010,
    S_OSCAN = 12'b000000000100,
    S_CSCAN = 12'b000000001000,
    S_SPLIT = 12'b000000010000,
    S_FCHK  = 12'b000000100000,
    S_MTEST = 12'b000001000000,
    S_BCHK  = 12'b000010000000,
    S_MLO   = 12'b000100000000,
    S_SGO   = 12'b001000000000,
    S_SWAIT = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // Config register.
  logic [HDR_W-1:0] hdr_q;

  // Request and working registers.
  logic               op_q;
  logic [SIZE_W-1:0]  size_q;
  logic [BLOCK_W-1:0] bidx_q;
  logic [ORD_W-1:0]   ord_q;
  logic [IW-1:0]      o_q;
  logic [CELL_W-1:0]  c_q, addr_q, rd_addr_q;
  logic               pend_q;

  // Result of the current request.
  status_e            res_st_q;
  logic [BLOCK_W-1:0] res_bo_q;
  logic [BORD_W-1:0]  res_bord_q;

  // Output register.
  logic               ov_q;
  status_e            o_st_q;
  logic [BLOCK_W-1:0] o_bo_q;
  logic [BORD_W-1:0]  o_bord_q;
  logic [COUNT_W-1:0] o_fbk_q, o_tbk_q;
  logic [BYTES_W-1:0] o_fby_q, o_tby_q, o_ht_q;

  // Memory port and counter updates.
  logic              mem_en, mem_we, mem_busy;
  logic [CELL_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  cnt_upd_t          upd;
  logic              st_start, st_done;
  logic [MAX_ORDER:0] has_free;
  logic [COUNT_W-1:0] st_fbk, st_tbk;
  logic [BYTES_W-1:0] st_fby, st_tby, st_ht;

  logic              in_acc, out_load;
  logic [NEED_W-1:0] need;
  logic              too_big, out_range;
  logic [ORD_W-1:0]  need_ord, o_ord, o_m1;
  logic              rd_head, rd_free;
  logic [ORD_W-1:0]  rd_ord;
  logic              scan_hit, free_ok, bud_ok;
  logic [CELL_W-1:0] bit_o, half, bud;

  function automatic logic [ORD_W-1:0] need_order(input logic [NEED_W-1:0] nd);
    logic [ORD_W-1:0] r;
    logic             hit;
    r   = ORD_W'(MAX_ORDER);
    hit = 1'b0;
    for (int i = 0; i <= MAX_ORDER; i++) begin
      if (!hit && (64'(nd) < (64'(MIN_BLOCK_BYTES) << i))) begin
        r   = ORD_W'(i);
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  bba_cell_mem #(
    .TOP_BLOCKS (TOP_BLOCKS),
    .MAX_ORDER  (MAX_ORDER)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  bba_stats #(
    .TOP_BLOCKS      (TOP_BLOCKS),
    .MAX_ORDER       (MAX_ORDER),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_stats (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (upd),
    .hdr_i          (hdr_q),
    .start_i        (st_start),
    .done_o         (st_done),
    .has_free_o     (has_free),
    .free_blocks_o  (st_fbk),
    .free_bytes_o   (st_fby),
    .total_blocks_o (st_tbk),
    .total_bytes_o  (st_tby),
    .header_total_o (st_ht)
  );

  // Handshakes: accept only when idle and the cell store is rebuilt.
  assign in_i.ready = (state_q == S_IDLE) && !mem_busy;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_DONE) && (!ov_q || out_o.ready);

  // Request decode.
  assign need      = NEED_W'(size_q) + NEED_W'(hdr_q);
  assign too_big   = 64'(need) > TOP_BYTES;
  assign need_ord  = need_order(need);
  assign out_range = 32'(bidx_q) >= CELLS;

  // Fields of the cell word just read.
  assign rd_head = mem_rdata[ORD_W+1];
  assign rd_free = mem_rdata[ORD_W];
  assign rd_ord  = mem_rdata[ORD_W-1:0];

  assign o_ord = o_q[ORD_W-1:0];
  assign o_m1  = ORD_W'(o_q - IW'(1));
  assign bit_o = CELL_W'(1) << o_q;
  assign half  = CELL_W'(1) << o_m1;
  assign bud   = c_q ^ bit_o;

  assign scan_hit = pend_q && rd_head && rd_free && (rd_ord == o_ord);
  assign free_ok  = rd_head && !rd_free && (rd_ord <= ORD_W'(MAX_ORDER));
  assign bud_ok   = rd_head && rd_free && (rd_ord == o_ord);

  always_comb begin
    state_d   = state_q;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = c_q;
    mem_wdata = '0;
    upd.kind  = CMD_NONE;
    upd.ord   = '0;
    st_start  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_PREP;
      end
      S_PREP: begin
        if (op_q == OP_ALLOC) begin
          state_d = too_big ? S_SGO : S_OSCAN;
        end else if (out_range) begin
          state_d = S_SGO;
        end else begin
          mem_en   = 1'b1;
          mem_addr = CELL_W'(bidx_q);
          state_d  = S_FCHK;
        end
      end
      S_OSCAN: begin
        // Advance to the smallest order at or above the need that has a free block.
        if (o_q > IW'(MAX_ORDER)) begin
          state_d = S_SGO;
        end else if (has_free[o_ord]) begin
          state_d = S_CSCAN;
        end
      end
      S_CSCAN: begin
        // Stream reads over block starts; check each word in the cycle after its read.
        if (scan_hit) begin
          state_d = S_SPLIT;
        end else begin
          mem_en   = 1'b1;
          mem_addr = addr_q;
        end
      end
      S_SPLIT: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        if (o_q > IW'(ord_q)) begin
          mem_addr  = c_q + half;
          mem_wdata = {1'b1, 1'b1, o_m1};
          upd.kind  = CMD_SPLIT;
          upd.ord   = UPD_ORD_W'(o_m1);
        end else begin
          mem_addr  = c_q;
          mem_wdata = {1'b1, 1'b0, ord_q};
          upd.kind  = CMD_TAKE;
          upd.ord   = UPD_ORD_W'(ord_q);
          state_d   = S_SGO;
        end
      end
      S_FCHK: begin
        if (free_ok) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = c_q;
          mem_wdata = {1'b1, 1'b1, rd_ord};
          upd.kind  = CMD_MARK;
          upd.ord   = UPD_ORD_W'(rd_ord);
          state_d   = S_MTEST;
        end else begin
          state_d = S_SGO;
        end
      end
      S_MTEST: begin
        if (o_q >= IW'(MAX_ORDER)) begin
          state_d = S_SGO;
        end else begin
          mem_en   = 1'b1;
          mem_addr = bud;
          state_d  = S_BCHK;
        end
      end
      S_BCHK: begin
        // Buddy whole and free at the same order: drop the upper head.
        if (bud_ok) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = c_q | bit_o;
          mem_wdata = '0;
          state_d   = S_MLO;
        end else begin
          state_d = S_SGO;
        end
      end
      S_MLO: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = c_q & ~bit_o;
        mem_wdata = {1'b1, 1'b1, ORD_W'(o_q + IW'(1))};
        upd.kind  = CMD_MERGE;
        upd.ord   = UPD_ORD_W'(o_q);
        state_d   = S_MTEST;
      end
      S_SGO: begin
        st_start = 1'b1;
        state_d  = S_SWAIT;
      end
      S_SWAIT: begin
        if (st_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hdr_q   <= HDR_RESET;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) hdr_q <= cfg_data_i;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      if (state_q == S_OSCAN) begin
        pend_q <= 1'b0;
      end else if (state_q == S_CSCAN) begin
        pend_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q   <= in_i.op;
          size_q <= in_i.size;
          bidx_q <= in_i.block_index;
        end
      end
      S_PREP: begin
        res_bo_q   <= '0;
        res_bord_q <= '0;
        if (op_q == OP_ALLOC) begin
          res_st_q <= ST_TOO_BIG;
          ord_q    <= need_ord;
          o_q      <= IW'(need_ord);
        end else begin
          res_st_q <= ST_IGNORED;
          c_q      <= CELL_W'(bidx_q);
        end
      end
      S_OSCAN: begin
        addr_q <= '0;
        if (o_q > IW'(MAX_ORDER)) begin
          res_st_q   <= ST_NO_BLOCK;
          res_bord_q <= BORD_W'(ord_q);
        end else if (!has_free[o_ord]) begin
          o_q <= o_q + IW'(1);
        end
      end
      S_CSCAN: begin
        if (scan_hit) begin
          c_q <= rd_addr_q;
        end else begin
          rd_addr_q <= addr_q;
          addr_q    <= addr_q + bit_o;
        end
      end
      S_SPLIT: begin
        if (o_q > IW'(ord_q)) begin
          o_q <= o_q - IW'(1);
        end else begin
          res_st_q   <= ST_OK;
          res_bo_q   <= BLOCK_W'(c_q);
          res_bord_q <= BORD_W'(ord_q);
        end
      end
      S_FCHK: begin
        if (free_ok) begin
          res_st_q   <= ST_OK;
          res_bo_q   <= bidx_q;
          res_bord_q <= BORD_W'(rd_ord);
          o_q        <= IW'(rd_ord);
        end
      end
      S_MLO: begin
        c_q <= c_q & ~bit_o;
        o_q <= o_q + IW'(1);
      end
      S_DONE: begin
        if (out_load) begin
          o_st_q   <= res_st_q;
          o_bo_q   <= res_bo_q;
          o_bord_q <= res_bord_q;
          o_fbk_q  <= st_fbk;
          o_fby_q  <= st_fby;
          o_tbk_q  <= st_tbk;
          o_tby_q  <= st_tby;
          o_ht_q   <= st_ht;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid        = ov_q;
  assign out_o.status       = o_st_q;
  assign out_o.block_out    = o_bo_q;
  assign out_o.block_order  = o_bord_q;
  assign out_o.free_blocks  = o_fbk_q;
  assign out_o.free_bytes   = o_fby_q;
  assign out_o.total_blocks = o_tbk_q;
  assign out_o.total_bytes  = o_tby_q;
  assign out_o.header_total = o_ht_q;
endmodule
